// ===== rtl/shrv_pkg.sv =====
// ----------------------------------------------------------------------------
// shrv_pkg
// Shared types, constants and tables of the reduced-round SHA-256 block.
// ----------------------------------------------------------------------------
package shrv_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 8;
  localparam int unsigned PackW    = 64;
  localparam int unsigned NumPack  = 4;
  localparam int unsigned RoundsW  = 7;
  localparam int unsigned ValW     = 9;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [RoundsW-1:0] MaxRounds = 7'd64;
  localparam logic [ValW-1:0]    ValEqual  = 9'd256;

  typedef logic [NumWords-1:0][WordW-1:0] state_t;
  typedef logic [NumPack-1:0][PackW-1:0]  pack_t;

  // result fields travelling from the round stage to the output stage
  typedef struct packed {
    pack_t              packed_word;
    logic [RoundsW-1:0] rounds;
    logic               ovf;
  } pend_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTarget0 = 8'd0,
    CfgTarget1 = 8'd1,
    CfgTarget2 = 8'd2,
    CfgTarget3 = 8'd3
  } cfg_idx_e;

  // word 0 sits at index 0
  localparam state_t InitH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [WordW-1:0] round_k(input logic [5:0] idx);
    return RoundK[idx];
  endfunction

endpackage

// ===== rtl/shrv_ifs.sv =====
// ----------------------------------------------------------------------------
// shrv channel interfaces
// Valid/ready channels for round words, results and configuration writes.
// ----------------------------------------------------------------------------
interface shrv_in_if import shrv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] round_word;
  logic             last;

  modport source (output valid, round_word, last, input ready);
  modport sink   (input valid, round_word, last, output ready);
endinterface

interface shrv_out_if import shrv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PackW-1:0]   packed_word0;
  logic [PackW-1:0]   packed_word1;
  logic [PackW-1:0]   packed_word2;
  logic [PackW-1:0]   packed_word3;
  logic [ValW-1:0]    valuation;
  logic [RoundsW-1:0] rounds_done;
  logic               overflow;

  modport source (output valid, packed_word0, packed_word1, packed_word2, packed_word3,
                  valuation, rounds_done, overflow, input ready);
  modport sink   (input valid, packed_word0, packed_word1, packed_word2, packed_word3,
                  valuation, rounds_done, overflow, output ready);
endinterface

interface shrv_cfg_if import shrv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [PackW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/shrv_round.sv =====
// ----------------------------------------------------------------------------
// shrv_round
// One SHA-256 compression round on the eight working words.
// ----------------------------------------------------------------------------
module shrv_round import shrv_pkg::*; (
  input  state_t           state_i,
  input  logic [WordW-1:0] k_i,
  input  logic [WordW-1:0] w_i,
  output state_t           state_o
);

  logic [WordW-1:0] a, b, c, d, e, f, g, h;
  logic [WordW-1:0] sum0, sum1, ch, maj, t1, t2;

  assign a = state_i[0];
  assign b = state_i[1];
  assign c = state_i[2];
  assign d = state_i[3];
  assign e = state_i[4];
  assign f = state_i[5];
  assign g = state_i[6];
  assign h = state_i[7];

  assign sum1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign ch   = (e & f) ^ (~e & g);
  assign sum0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign maj  = (a & b) ^ (a & c) ^ (b & c);
  assign t1   = h + sum1 + ch + k_i + w_i;
  assign t2   = sum0 + maj;

  assign state_o[0] = t1 + t2;
  assign state_o[1] = a;
  assign state_o[2] = b;
  assign state_o[3] = c;
  assign state_o[4] = d + t1;
  assign state_o[5] = e;
  assign state_o[6] = f;
  assign state_o[7] = g;

endmodule

// ===== rtl/shrv_valuation.sv =====
// ----------------------------------------------------------------------------
// shrv_valuation
// Lowest differing bit between packed state and target, 256 when equal.
// ----------------------------------------------------------------------------
module shrv_valuation import shrv_pkg::*; (
  input  pack_t           state_i,
  input  pack_t           target_i,
  output logic [ValW-1:0] valuation_o
);

  // trailing zero count, binary search; only used on a nonzero word
  function automatic logic [5:0] tz64(input logic [PackW-1:0] x);
    logic [PackW-1:0] v;
    logic [5:0]       pos;
    v   = x;
    pos = '0;
    if (v[31:0] == '0) begin pos[5] = 1'b1; v = v >> 32; end
    if (v[15:0] == '0) begin pos[4] = 1'b1; v = v >> 16; end
    if (v[7:0]  == '0) begin pos[3] = 1'b1; v = v >> 8;  end
    if (v[3:0]  == '0) begin pos[2] = 1'b1; v = v >> 4;  end
    if (v[1:0]  == '0) begin pos[1] = 1'b1; v = v >> 2;  end
    if (v[0]    == 1'b0) begin pos[0] = 1'b1; end
    return pos;
  endfunction

  pack_t                    diff;
  logic [NumPack-1:0][5:0]  tz;
  logic [NumPack-1:0]       nz;

  always_comb begin
    for (int i = 0; i < NumPack; i++) begin
      diff[i] = state_i[i] ^ target_i[i];
      nz[i]   = diff[i] != '0;
      tz[i]   = tz64(diff[i]);
    end
  end

  always_comb begin
    priority if (nz[0]) begin
      valuation_o = {3'd0, tz[0]};
    end else if (nz[1]) begin
      valuation_o = {3'd1, tz[1]};
    end else if (nz[2]) begin
      valuation_o = {3'd2, tz[2]};
    end else if (nz[3]) begin
      valuation_o = {3'd3, tz[3]};
    end else begin
      valuation_o = ValEqual;
    end
  end

endmodule

// ===== rtl/sha256_reduced_rounds_valuation.sv =====
// ----------------------------------------------------------------------------
// sha256_reduced_rounds_valuation
// SHA-256 rounds on fed words, packed-state compare against a 256-bit target.
// ----------------------------------------------------------------------------
// Accepts one round word per clock cycle, back to back, unless the input is
// stalled; the round adder chain into the working-word registers sets that
// rate. A word with last set yields one result: the round stage registers the
// packed state, then the valuation stage registers the result. The input
// stalls only while a finished result is held in both stages. Target
// registers are written through the config channel (index 0..3, others
// ignored) and must only change while no run result is in flight.
// ----------------------------------------------------------------------------
module sha256_reduced_rounds_valuation import shrv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  shrv_in_if.sink    in_i,
  shrv_out_if.source out_o,
  shrv_cfg_if.sink   cfg_i
);

  state_t             state_q, state_d;
  logic [RoundsW-1:0] cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  pack_t              target_q;
  pend_t              pend_q, pend_d;
  logic               pend_v_q, pend_v_d;
  pend_t              res_q, res_d;
  logic [ValW-1:0]    val_q, val_d;
  logic               out_v_q, out_v_d;

  state_t             round_state, applied_state;
  logic               in_fire, room, out_free, pend_move;

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_free  = !out_v_q || out_o.ready;
  assign pend_move = pend_v_q && out_free;
  assign in_i.ready  = !pend_v_q || out_free;
  assign cfg_i.ready = 1'b1;
  assign room      = cnt_q < MaxRounds;

  shrv_round u_round (
    .state_i (state_q),
    .k_i     (round_k(cnt_q[5:0])),
    .w_i     (in_i.round_word),
    .state_o (round_state)
  );

  assign applied_state = room ? round_state : state_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q && !pend_move;
    if (in_fire) begin
      for (int i = 0; i < NumPack; i++) begin
        pend_d.packed_word[i] = {applied_state[2*i+1], applied_state[2*i]};
      end
      pend_d.rounds = room ? cnt_q + 7'd1 : cnt_q;
      pend_d.ovf    = ovf_q || !room;
      if (in_i.last) begin
        state_d  = InitH;
        cnt_d    = '0;
        ovf_d    = 1'b0;
        pend_v_d = 1'b1;
      end else begin
        state_d  = applied_state;
        cnt_d    = pend_d.rounds;
        ovf_d    = pend_d.ovf;
        pend_d   = pend_q;
      end
    end
  end

  shrv_valuation u_valuation (
    .state_i     (pend_q.packed_word),
    .target_i    (target_q),
    .valuation_o (val_d)
  );

  assign res_d   = pend_move ? pend_q : res_q;
  assign out_v_d = pend_move || (out_v_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= InitH;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      target_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CfgTarget0: target_q[0] <= cfg_i.data;
          CfgTarget1: target_q[1] <= cfg_i.data;
          CfgTarget2: target_q[2] <= cfg_i.data;
          CfgTarget3: target_q[3] <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
    if (pend_move) begin
      val_q <= val_d;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.packed_word0 = res_q.packed_word[0];
  assign out_o.packed_word1 = res_q.packed_word[1];
  assign out_o.packed_word2 = res_q.packed_word[2];
  assign out_o.packed_word3 = res_q.packed_word[3];
  assign out_o.valuation    = val_q;
  assign out_o.rounds_done  = res_q.rounds;
  assign out_o.overflow     = res_q.ovf;

endmodule

// ===== rtl/shrv_checker.sv =====
// ----------------------------------------------------------------------------
// shrv_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module shrv_checker import shrv_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [ValW-1:0]    valuation_i,
  input logic [RoundsW-1:0] rounds_done_i,
  input logic               overflow_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(valuation_i)
      && $stable(rounds_done_i) && $stable(overflow_i))
    else $error("result dropped or changed while stalled");

  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> valuation_i <= ValEqual)
    else $error("valuation beyond 256");

  a_rounds_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> rounds_done_i <= MaxRounds)
    else $error("rounds_done beyond limit");

  // overflow only after the round budget is spent
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflow_i |-> rounds_done_i == MaxRounds)
    else $error("overflow with rounds left");

endmodule

bind sha256_reduced_rounds_valuation shrv_checker u_shrv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .valuation_i   (out_o.valuation),
  .rounds_done_i (out_o.rounds_done),
  .overflow_i    (out_o.overflow)
);

// ===== dv/shrv_digest_track_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shrv_digest_track_pkg
// Tracks the round state of the reduced-round SHA-256 block and holds the
// packed digests and valuations still due at its output.
// ----------------------------------------------------------------------------
package shrv_digest_track_pkg;
  import shrv_pkg::*;

  // indexes outside the target map, used to show that such writes are dropped
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgTopIndex = 8'hff;

  localparam int unsigned RoundLimit = 64;
  localparam int unsigned NoDiff     = 256;
  localparam int unsigned TargetW    = NumPack * PackW;

  localparam logic [WordW-1:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WordW-1:0] IvTab [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    pack_t              words;
    logic [ValW-1:0]    val;
    logic [RoundsW-1:0] rounds;
    logic               ovf;
  } digest_t;

  class round_state_tracker;
    logic [WordW-1:0]   work [NumWords];
    int unsigned        applied;
    logic               overran;
    logic [TargetW-1:0] target;
    pack_t              last_packed;
    digest_t            pending_digests [$];
    int unsigned        errors;
    int unsigned        digests_seen;

    function new();
      target       = '0;
      last_packed  = '0;
      errors       = 0;
      digests_seen = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < NumWords; i++) work[i] = IvTab[i];
      applied = 0;
      overran = 1'b0;
    endfunction

    function logic [WordW-1:0] ror(logic [WordW-1:0] x, int unsigned n);
      return (x >> n) | (x << (WordW - n));
    endfunction

    function void one_round(logic [WordW-1:0] w);
      logic [WordW-1:0] a, e, big1, choose, t1, big0, major, t2;
      a      = work[0];
      e      = work[4];
      big1   = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
      choose = (e & work[5]) ^ (~e & work[6]);
      t1     = work[7] + big1 + choose + KTab[applied] + w;
      big0   = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
      major  = (a & work[1]) ^ (a & work[2]) ^ (work[1] & work[2]);
      t2     = big0 + major;
      for (int i = NumWords - 1; i > 0; i--) work[i] = work[i-1];
      work[4] = work[4] + t1;
      work[0] = t1 + t2;
    endfunction

    function void set_target(logic [CfgIdxW-1:0] idx, logic [PackW-1:0] data);
      case (idx)
        CfgTarget0: target[0*PackW +: PackW] = data;
        CfgTarget1: target[1*PackW +: PackW] = data;
        CfgTarget2: target[2*PackW +: PackW] = data;
        CfgTarget3: target[3*PackW +: PackW] = data;
        default: ;
      endcase
    endfunction

    // note one accepted round word; a word marked last closes the run
    function void absorb_word(logic [WordW-1:0] w, logic last);
      digest_t            d;
      logic [TargetW-1:0] diff;
      if (applied < RoundLimit) begin
        one_round(w);
        applied++;
      end else begin
        overran = 1'b1;
      end
      if (last) begin
        for (int i = 0; i < NumPack; i++) d.words[i] = {work[2*i+1], work[2*i]};
        diff  = d.words ^ target;
        d.val = ValW'(NoDiff);
        for (int b = TargetW - 1; b >= 0; b--) if (diff[b]) d.val = ValW'(b);
        d.rounds = RoundsW'(applied);
        d.ovf    = overran;
        pending_digests.push_back(d);
        last_packed = d.words;
        restart();
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("ERROR: %s", msg);
    endtask

    task check_digest(digest_t got);
      digest_t want;
      digests_seen++;
      if (pending_digests.size() == 0) begin
        report($sformatf("result with no run pending (valuation %0d)", got.val));
        return;
      end
      want = pending_digests.pop_front();
      for (int i = 0; i < NumPack; i++)
        if (got.words[i] !== want.words[i])
          report($sformatf("packed_word%0d got %h want %h", i, got.words[i],
                           want.words[i]));
      if (got.val !== want.val)
        report($sformatf("valuation got %0d want %0d", got.val, want.val));
      if (got.rounds !== want.rounds)
        report($sformatf("rounds_done got %0d want %0d", got.rounds, want.rounds));
      if (got.ovf !== want.ovf)
        report($sformatf("overflow got %b want %b", got.ovf, want.ovf));
    endtask
  endclass

endpackage

// ===== dv/sha256_reduced_rounds_valuation_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_reduced_rounds_valuation_test
// Feeds runs of round words, short and long, some past the round limit,
// under random valid and ready gaps. Targets are rewritten between runs,
// partly aimed at the previous run's packed state so that equal and near
// equal cases show up. Every result is checked against a tracked copy of
// the round state.
// ----------------------------------------------------------------------------
module sha256_reduced_rounds_valuation_test;
  import shrv_pkg::*;
  import shrv_digest_track_pkg::*;

  localparam int unsigned ItemGoal   = 1200;
  localparam int unsigned DigestGoal = 40;
  localparam int unsigned Settle     = 4;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bit               in_burst   = 1'b0;
  bit               out_burst  = 1'b0;
  int unsigned      words_sent = 0;
  logic [WordW-1:0] prev_run [$];

  round_state_tracker tracker;

  shrv_in_if  in_if ();
  shrv_out_if out_if ();
  shrv_cfg_if cfg_if ();

  sha256_reduced_rounds_valuation i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // mostly well-formed runs, a share of them past the round limit
  function automatic int unsigned draw_run_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return $urandom_range(1, 8);
    if (pick < 75) return $urandom_range(9, RoundLimit - 1);
    if (pick < 87) return RoundLimit;
    return $urandom_range(RoundLimit + 1, RoundLimit + 16);
  endfunction

  task automatic send_word(input logic [WordW-1:0] w, input logic last);
    int unsigned gap;
    gap = draw_wait(in_burst);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.round_word <= w;
    in_if.last       <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tracker.absorb_word(w, last);
    words_sent++;
  endtask

  task automatic play_run(input logic [WordW-1:0] words [$]);
    prev_run = words;
    foreach (words[i]) send_word(words[i], i == words.size() - 1);
  endtask

  task automatic send_random_run(input int unsigned len);
    logic [WordW-1:0] words [$];
    repeat (len) words.push_back(rand_word());
    play_run(words);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [PackW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    tracker.set_target(idx, data);
  endtask

  task automatic write_targets(input logic [TargetW-1:0] t, input bit unmapped);
    cfg_write(CfgTarget0, t[0*PackW +: PackW]);
    cfg_write(CfgTarget1, t[1*PackW +: PackW]);
    cfg_write(CfgTarget2, t[2*PackW +: PackW]);
    cfg_write(CfgTarget3, t[3*PackW +: PackW]);
    if (unmapped) begin
      cfg_write(CfgUnmapped, {$urandom(), $urandom()});
      cfg_write(CfgTopIndex, '0);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // target = previous packed state, optionally with one bit flipped
  task automatic aim_at_previous(input int flip);
    logic [TargetW-1:0] t;
    t = tracker.last_packed;
    if (flip >= 0) t[flip] = ~t[flip];
    write_targets(t, 1'b0);
  endtask

  // the block may still hold a run's tail after the last result
  task automatic settle();
    in_if.valid <= 1'b0;
    while (tracker.pending_digests.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [WordW-1:0] q [$];
    int               flip;
    tracker = new();
    in_if.valid      <= 1'b0;
    in_if.round_word <= '0;
    in_if.last       <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CfgTarget0;
    cfg_if.data      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short runs at the word extremes, against the zero target
    q = {32'h0000_0000};
    play_run(q);
    q = {32'hffff_ffff};
    play_run(q);
    q = {32'h0000_0000, 32'hffff_ffff};
    play_run(q);
    settle();

    write_targets('1, 1'b1);
    q = {32'h1234_5678, 32'hdead_beef, 32'h8000_0001};
    play_run(q);
    settle();

    // equal state, then a lone difference at the top, bottom and middle
    aim_at_previous(-1);
    play_run(prev_run);
    settle();
    aim_at_previous(TargetW - 1);
    play_run(prev_run);
    settle();
    aim_at_previous(0);
    play_run(prev_run);
    settle();
    aim_at_previous(TargetW / 2);
    play_run(prev_run);
    settle();

    while (words_sent < ItemGoal || tracker.digests_seen < DigestGoal) begin
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: write_targets({$urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom(), $urandom()},
                         1'($urandom_range(0, 1)));
        1: write_targets('0, 1'b0);
        2: write_targets('1, 1'b0);
        3, 4: begin
          flip = ($urandom_range(0, 2) == 0) ? -1 : int'($urandom_range(0, TargetW - 1));
          aim_at_previous(flip);
          play_run(prev_run);
        end
        default: ;
      endcase
      repeat ($urandom_range(1, 4)) send_random_run(draw_run_len());
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("sha256_reduced_rounds_valuation regression: pass");
    end else begin
      $display("sha256_reduced_rounds_valuation regression: fail");
    end
    $finish;
  end

  initial begin : result_sink
    digest_t     got;
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(out_burst);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      got.words[0] = out_if.packed_word0;
      got.words[1] = out_if.packed_word1;
      got.words[2] = out_if.packed_word2;
      got.words[3] = out_if.packed_word3;
      got.val      = out_if.valuation;
      got.rounds   = out_if.rounds_done;
      got.ovf      = out_if.overflow;
      tracker.check_digest(got);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("sha256_reduced_rounds_valuation regression: fail");
    $finish;
  end

endmodule
